// ===== hw/rtl/grid_fov_ray_caster_unit_macros.svh =====
// ---------------------------------------------------------------------------
// grid_fov_ray_caster_unit_macros.svh
// Assertion macros shared by the ray caster RTL.
// ---------------------------------------------------------------------------
`ifndef GRID_FOV_RAY_CASTER_UNIT_MACROS_SVH
`define GRID_FOV_RAY_CASTER_UNIT_MACROS_SVH

// Check a property outside reset.
`define GFOV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define GFOV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gfov_pkg.sv =====
// ---------------------------------------------------------------------------
// gfov_pkg
// Types, constants and the ray direction table of the grid ray caster.
// ---------------------------------------------------------------------------
package gfov_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int Cells     = MaxWidth * MaxHeight;
  localparam int CellBits  = $clog2(Cells);
  localparam int RayCount  = 720;
  localparam int RayBits   = $clog2(RayCount);
  localparam int RayHalf   = RayCount / 2;
  localparam int DistBits  = 40;

  localparam logic [63:0] PiQ  = 64'd3373258724;
  localparam logic [63:0] OneQ = 64'd1073741824;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CAST  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ORIGIN,
    ST_RAY_LOAD,
    ST_RAY_INIT,
    ST_STEP,
    ST_WALL,
    ST_DONE
  } state_t;

  // Control word from the sequencer to the map memories.
  typedef struct packed {
    logic                wall_we;
    logic                wall_wd;
    logic                vis_we;
    logic                vis_wd;
    logic                expl_we;
    logic                expl_wd;
    logic [CellBits-1:0] wall_addr;
    logic [CellBits-1:0] wr_addr;
    logic [CellBits-1:0] rd_addr;
  } map_ctrl_t;

  // {neg_x, neg_y, step_len_x, step_len_y}
  typedef logic [65:0] dir_word_t;
  typedef dir_word_t dir_rom_t [RayCount];

  function automatic logic [63:0] taylor_term(logic [63:0] t, logic [63:0] x);
    return (((t * x) >> 30) * x) >> 30;
  endfunction

  function automatic logic signed [63:0] sin_q30(logic [63:0] x);
    logic [63:0] t;
    logic signed [63:0] s;
    t = x;
    s = $signed(x);
    t = taylor_term(t, x) / 6;   s = s - $signed(t);
    t = taylor_term(t, x) / 20;  s = s + $signed(t);
    t = taylor_term(t, x) / 42;  s = s - $signed(t);
    t = taylor_term(t, x) / 72;  s = s + $signed(t);
    t = taylor_term(t, x) / 110; s = s - $signed(t);
    t = taylor_term(t, x) / 156; s = s + $signed(t);
    t = taylor_term(t, x) / 210; s = s - $signed(t);
    return s;
  endfunction

  function automatic logic signed [63:0] cos_q30(logic [63:0] x);
    logic [63:0] t;
    logic signed [63:0] s;
    t = OneQ;
    s = $signed(OneQ);
    t = taylor_term(t, x) / 2;   s = s - $signed(t);
    t = taylor_term(t, x) / 12;  s = s + $signed(t);
    t = taylor_term(t, x) / 30;  s = s - $signed(t);
    t = taylor_term(t, x) / 56;  s = s + $signed(t);
    t = taylor_term(t, x) / 90;  s = s - $signed(t);
    t = taylor_term(t, x) / 132; s = s + $signed(t);
    t = taylor_term(t, x) / 182; s = s - $signed(t);
    return s;
  endfunction

  // Q16.16 reciprocal of a Q30 magnitude by restoring division, saturated.
  function automatic logic [31:0] recip_q16(logic [63:0] mag);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    if (mag == 64'd0) begin
      return 32'hFFFF_FFFF;
    end
    for (int j = 46; j >= 0; j--) begin
      rem = {rem[62:0], (j == 46) ? 1'b1 : 1'b0};
      if (rem >= mag) begin
        rem  = rem - mag;
        q[j] = 1'b1;
      end
    end
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic dir_rom_t build_dir_rom();
    dir_rom_t rom;
    logic [63:0] th;
    logic sflip;
    logic cflip;
    logic signed [63:0] s;
    logic signed [63:0] c;
    for (int i = 0; i < RayCount; i++) begin
      th = (64'(i) * PiQ) / RayHalf;
      sflip = 1'b0;
      cflip = 1'b0;
      if (th >= 2 * PiQ) th = th - 2 * PiQ;
      if (th >= PiQ) begin
        th    = th - PiQ;
        sflip = 1'b1;
        cflip = 1'b1;
      end
      if (th > PiQ / 2) begin
        th    = PiQ - th;
        cflip = ~cflip;
      end
      s = sin_q30(th);
      c = cos_q30(th);
      if (sflip) s = -s;
      if (cflip) c = -c;
      rom[i] = {c < 0, s < 0,
                recip_q16((c < 0) ? 64'(-c) : 64'(c)),
                recip_q16((s < 0) ? 64'(-s) : 64'(s))};
    end
    return rom;
  endfunction

  localparam dir_rom_t DirRom = build_dir_rom();

endpackage

// ===== hw/rtl/gfov_maps.sv =====
// ---------------------------------------------------------------------------
// gfov_maps
// Wall, visible and explored bit maps, one write and one registered read each.
// ---------------------------------------------------------------------------
module gfov_maps (
  input  logic                clk,
  input  gfov_pkg::map_ctrl_t ctrl,
  output logic                rd_wall,
  output logic                rd_vis,
  output logic                rd_expl
);

  logic wall_mem [gfov_pkg::Cells];
  logic vis_mem  [gfov_pkg::Cells];
  logic expl_mem [gfov_pkg::Cells];

  // Write ports
  always_ff @(posedge clk) begin
    if (ctrl.wall_we) begin
      wall_mem[ctrl.wall_addr] <= ctrl.wall_wd;
    end
    if (ctrl.vis_we) begin
      vis_mem[ctrl.wr_addr] <= ctrl.vis_wd;
    end
    if (ctrl.expl_we) begin
      expl_mem[ctrl.wr_addr] <= ctrl.expl_wd;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rd_wall <= wall_mem[ctrl.rd_addr];
    rd_vis  <= vis_mem[ctrl.rd_addr];
    rd_expl <= expl_mem[ctrl.rd_addr];
  end

endmodule

// ===== hw/rtl/grid_fov_ray_caster_unit.sv =====
// ---------------------------------------------------------------------------
// grid_fov_ray_caster_unit
// Tile map field of view: wall writes, cell reads, DDA ray cast, clears.
// ---------------------------------------------------------------------------
// Channel   Ports                                        Handshake
// input     in_command, in_cell_index, in_wall_bit,      start & !busy
//           in_origin_x, in_origin_y, in_sight_radius
// result    out_cell_visible, out_cell_explored,         out_strobe, 1 cycle
//           out_cell_wall, out_echo_command
// config    cfg_we, cfg_index, cfg_wdata                 cfg_we
//
// Write and read leave the unit ready; the word comes out on the next cycle.
// Clear sweeps the explored map, one map entry per cycle. Cast clears the
// visible map and marks the origin, then per ray loads the direction table
// and sets the ray up, and per cell entered makes one DDA step and one wall
// read, ending the ray at the map edge, a wall or the sight radius; a
// final state emits the word. After reset both maps are cleared while busy.
// The receiver cannot stall; a result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`include "grid_fov_ray_caster_unit_macros.svh"

module grid_fov_ray_caster_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [11:0] in_cell_index,
  input  logic       in_wall_bit,
  input  logic [5:0] in_origin_x,
  input  logic [5:0] in_origin_y,
  input  logic [5:0] in_sight_radius,
  output logic       out_strobe,
  output logic       out_cell_visible,
  output logic       out_cell_explored,
  output logic       out_cell_wall,
  output logic [1:0] out_echo_command,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [6:0] cfg_wdata
);

  localparam int CB = gfov_pkg::CellBits;
  localparam int RB = gfov_pkg::RayBits;
  localparam int DB = gfov_pkg::DistBits;

  gfov_pkg::state_t state_r, state_nxt;

  logic [6:0]    map_w_r, map_h_r;
  logic [6:0]    eff_w, eff_h;
  logic [13:0]   limit;
  logic          accept;

  gfov_pkg::cmd_t cmd_r;
  logic          boot_r;
  logic          clr_vis_r, clr_expl_r;
  logic [CB-1:0] clr_addr_r;
  logic [5:0]    ox_r, oy_r;
  logic [11:0]   r2_r;
  logic [RB-1:0] ray_r;
  gfov_pkg::dir_word_t rom_r;

  logic signed [7:0] px_r, py_r;
  logic [13:0]   sumsq_r;
  logic [6:0]    dx_r, dy_r;
  logic [DB-1:0] distx_r, disty_r;
  logic [31:0]   lenx_r, leny_r;
  logic          negx_r, negy_r;

  logic          out_strobe_r;
  logic [1:0]    out_echo_r;
  logic          rd_hit_r;

  // Step datapath
  logic              take_x;
  logic signed [7:0] px_n, py_n;
  logic              off_map;
  logic [12:0]       step_prod;
  logic [CB-1:0]     step_idx;
  logic [12:0]       org_prod;
  logic [CB-1:0]     org_idx;
  logic              org_in;
  logic              ray_last;
  logic              clr_last;

  // Control word and per-state strobes
  gfov_pkg::map_ctrl_t mctrl;
  logic          rd_wall, rd_vis, rd_expl;
  logic          ray_end;

  // Clamp the map size registers
  always_comb begin
    eff_w = (map_w_r == 7'd0) ? 7'd1 :
            (map_w_r > 7'(gfov_pkg::MaxWidth)) ? 7'(gfov_pkg::MaxWidth) : map_w_r;
    eff_h = (map_h_r == 7'd0) ? 7'd1 :
            (map_h_r > 7'(gfov_pkg::MaxHeight)) ? 7'(gfov_pkg::MaxHeight) : map_h_r;
    limit = 14'(eff_w * eff_h);
  end

  assign busy   = (state_r != gfov_pkg::ST_IDLE);
  assign accept = start && !busy;

  // DDA step: pick axis, advance, test bounds, form index
  always_comb begin
    take_x = (distx_r <= disty_r);
    px_n = px_r;
    py_n = py_r;
    if (take_x) begin
      px_n = negx_r ? px_r - 8'sd1 : px_r + 8'sd1;
    end else begin
      py_n = negy_r ? py_r - 8'sd1 : py_r + 8'sd1;
    end
    off_map = (px_n < 8'sd0) || (px_n >= $signed({1'b0, eff_w})) ||
              (py_n < 8'sd0) || (py_n >= $signed({1'b0, eff_h}));
    step_prod = 13'(py_n[6:0] * eff_w) + 13'(px_n[6:0]);
    step_idx  = step_prod[CB-1:0];
    org_prod  = 13'(oy_r * eff_w) + 13'(ox_r);
    org_idx   = org_prod[CB-1:0];
    org_in    = ({1'b0, ox_r} < eff_w) && ({1'b0, oy_r} < eff_h);
    ray_last  = (ray_r == RB'(gfov_pkg::RayCount - 1));
    clr_last  = (clr_addr_r == CB'(gfov_pkg::Cells - 1));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gfov_pkg::ST_IDLE: begin
        if (accept && (in_command == gfov_pkg::CMD_CAST ||
                       in_command == gfov_pkg::CMD_CLEAR)) begin
          state_nxt = gfov_pkg::ST_CLEAR;
        end
      end
      gfov_pkg::ST_CLEAR: begin
        if (clr_last) begin
          if (boot_r) begin
            state_nxt = gfov_pkg::ST_IDLE;
          end else if (cmd_r == gfov_pkg::CMD_CAST) begin
            state_nxt = gfov_pkg::ST_ORIGIN;
          end else begin
            state_nxt = gfov_pkg::ST_DONE;
          end
        end
      end
      gfov_pkg::ST_ORIGIN: begin
        state_nxt = org_in ? gfov_pkg::ST_RAY_LOAD : gfov_pkg::ST_DONE;
      end
      gfov_pkg::ST_RAY_LOAD: state_nxt = gfov_pkg::ST_RAY_INIT;
      gfov_pkg::ST_RAY_INIT: state_nxt = gfov_pkg::ST_STEP;
      gfov_pkg::ST_STEP: begin
        if (ray_end) begin
          state_nxt = ray_last ? gfov_pkg::ST_DONE : gfov_pkg::ST_RAY_LOAD;
        end else begin
          state_nxt = gfov_pkg::ST_WALL;
        end
      end
      gfov_pkg::ST_WALL: begin
        if (ray_end) begin
          state_nxt = ray_last ? gfov_pkg::ST_DONE : gfov_pkg::ST_RAY_LOAD;
        end else begin
          state_nxt = gfov_pkg::ST_STEP;
        end
      end
      gfov_pkg::ST_DONE: state_nxt = gfov_pkg::ST_IDLE;
      default: state_nxt = gfov_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory control and ray end
  always_comb begin
    mctrl         = '0;
    mctrl.wall_addr = in_cell_index;
    mctrl.wall_wd = in_wall_bit;
    mctrl.rd_addr = busy ? step_idx : in_cell_index;
    mctrl.wr_addr = step_idx;
    ray_end       = 1'b0;
    case (state_r)
      gfov_pkg::ST_IDLE: begin
        mctrl.wall_we = accept && (in_command == gfov_pkg::CMD_WRITE) &&
                        ({2'b00, in_cell_index} < limit);
      end
      gfov_pkg::ST_CLEAR: begin
        mctrl.wr_addr = clr_addr_r;
        mctrl.vis_we  = clr_vis_r;
        mctrl.expl_we = clr_expl_r;
      end
      gfov_pkg::ST_ORIGIN: begin
        mctrl.wr_addr = org_idx;
        mctrl.vis_we  = org_in;
        mctrl.vis_wd  = 1'b1;
        mctrl.expl_we = org_in;
        mctrl.expl_wd = 1'b1;
      end
      gfov_pkg::ST_STEP: begin
        ray_end       = off_map;
        mctrl.vis_we  = !off_map;
        mctrl.vis_wd  = 1'b1;
        mctrl.expl_we = !off_map;
        mctrl.expl_wd = 1'b1;
      end
      gfov_pkg::ST_WALL: begin
        ray_end = rd_wall || (sumsq_r > {2'b00, r2_r});
      end
      default: begin
        ray_end = 1'b0;
      end
    endcase
  end

  gfov_maps u_maps (
    .clk     (clk),
    .ctrl    (mctrl),
    .rd_wall (rd_wall),
    .rd_vis  (rd_vis),
    .rd_expl (rd_expl)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gfov_pkg::ST_CLEAR;
      boot_r       <= 1'b1;
      clr_vis_r    <= 1'b1;
      clr_expl_r   <= 1'b1;
      clr_addr_r   <= '0;
      map_w_r      <= 7'(gfov_pkg::MaxWidth);
      map_h_r      <= 7'(gfov_pkg::MaxHeight);
      out_strobe_r <= 1'b0;
      rd_hit_r     <= 1'b0;
      ray_r        <= '0;
    end else begin
      state_r <= state_nxt;
      // Take configuration writes
      if (cfg_we) begin
        if (cfg_index == gfov_pkg::CFG_MAP_WIDTH) map_w_r <= cfg_wdata;
        if (cfg_index == gfov_pkg::CFG_MAP_HEIGHT) map_h_r <= cfg_wdata;
      end
      // Advance the clearing sweep
      if (state_r == gfov_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_last ? '0 : clr_addr_r + CB'(1);
        if (clr_last) boot_r <= 1'b0;
      end
      if (accept) begin
        clr_vis_r  <= (in_command == gfov_pkg::CMD_CAST);
        clr_expl_r <= (in_command == gfov_pkg::CMD_CLEAR);
      end
      // Step through the rays, wrap after the last one
      if (state_r == gfov_pkg::ST_ORIGIN) begin
        ray_r <= '0;
      end else if ((state_r == gfov_pkg::ST_STEP || state_r == gfov_pkg::ST_WALL) &&
                   ray_end) begin
        ray_r <= ray_last ? '0 : ray_r + RB'(1);
      end
      // Emit one word per command
      out_strobe_r <= (accept && (in_command == gfov_pkg::CMD_WRITE ||
                                  in_command == gfov_pkg::CMD_READ)) ||
                      (state_r == gfov_pkg::ST_DONE);
      rd_hit_r <= accept && (in_command == gfov_pkg::CMD_READ) &&
                  ({2'b00, in_cell_index} < limit);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rom_r <= gfov_pkg::DirRom[ray_r];
    if (accept) begin
      cmd_r      <= gfov_pkg::cmd_t'(in_command);
      out_echo_r <= in_command;
      ox_r       <= in_origin_x;
      oy_r       <= in_origin_y;
      r2_r       <= 12'(in_sight_radius * in_sight_radius);
    end
    if (state_r == gfov_pkg::ST_DONE) begin
      out_echo_r <= cmd_r;
    end
    // Load a ray from the direction table
    if (state_r == gfov_pkg::ST_RAY_INIT) begin
      negx_r  <= rom_r[65];
      negy_r  <= rom_r[64];
      lenx_r  <= rom_r[63:32];
      leny_r  <= rom_r[31:0];
      distx_r <= DB'(rom_r[63:32]);
      disty_r <= DB'(rom_r[31:0]);
      px_r    <= $signed({2'b00, ox_r});
      py_r    <= $signed({2'b00, oy_r});
      dx_r    <= '0;
      dy_r    <= '0;
      sumsq_r <= '0;
    end
    // Advance one grid step
    if (state_r == gfov_pkg::ST_STEP) begin
      px_r <= px_n;
      py_r <= py_n;
      if (take_x) begin
        distx_r <= distx_r + DB'(lenx_r);
        dx_r    <= dx_r + 7'd1;
        sumsq_r <= sumsq_r + 14'({dx_r, 1'b1});
      end else begin
        disty_r <= disty_r + DB'(leny_r);
        dy_r    <= dy_r + 7'd1;
        sumsq_r <= sumsq_r + 14'({dy_r, 1'b1});
      end
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_echo_command  = out_echo_r;
  assign out_cell_visible  = rd_hit_r & rd_vis;
  assign out_cell_explored = rd_hit_r & rd_expl;
  assign out_cell_wall     = rd_hit_r & rd_wall;

  `GFOV_ASSERT(a_cast_goes_busy,
    (start && !busy && in_command == gfov_pkg::CMD_CAST) |=> busy,
    "cast accepted but unit not busy")
  `GFOV_ASSERT(a_word_only_idle,
    out_strobe |-> (state_r == gfov_pkg::ST_IDLE),
    "result word while sequencer active")
  `GFOV_ASSERT(a_step_in_map,
    (state_r == gfov_pkg::ST_STEP && mctrl.vis_we) |-> ({2'b00, step_idx} < limit),
    "ray marks a cell outside the map")
  `GFOV_ASSERT_ALWAYS(a_reset_quiet,
    !rst_n |=> !out_strobe,
    "result word right after reset")

endmodule
